@@ rtl/core/assert_macros.svh @@
// assertion macros shared by the rtl that checks itself
// no dependencies; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds this cycle, consequent holds the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// expression never true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

@@ rtl/core/cs0u_pkg.sv @@
// shared types and constants for the cs0 to utf-8 encoder
// no dependencies; used by cs0u_front, cs0u_serial and the top level
package cs0u_pkg;

  localparam logic [7:0] CODE_NARROW = 8'd8;
  localparam logic [7:0] CODE_WIDE   = 8'd16;

  localparam logic [15:0] ONE_BYTE_MAX = 16'h0080;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h0800;
  localparam logic [7:0]  LEAD2        = 8'hc0;
  localparam logic [7:0]  LEAD3        = 8'he0;
  localparam logic [7:0]  CONT         = 8'h80;
  localparam logic [8:0]  LEN_MAX      = 9'd511;

  // one result word of a run
  typedef struct packed {
    logic [7:0] data;
    logic       data_valid;
    logic [8:0] len;
  } slot_t;

  // all results caused by one input word
  typedef struct packed {
    slot_t [2:0] slot;
    logic [1:0]  count;
    logic        name_last;
    logic        bad;
  } run_t;

endpackage

@@ rtl/core/cs0u_front.sv @@
// input register, name state (mode, pairing, count) and run builder
// depends on cs0u_pkg
module cs0u_front #(
  parameter int NAME_LIMIT = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic [7:0]        compression_code,
  input  logic              first_of_name,
  input  logic              last_of_name,
  input  logic              empty_name,
  output logic              rec_valid,
  input  logic              rec_stall,
  output cs0u_pkg::run_t    rec
);
  import cs0u_pkg::*;

  localparam int CW = $clog2(NAME_LIMIT + 1);
  localparam int SW = (CW + 2 > 10) ? CW + 2 : 10;

  // input register
  logic       s0_valid;
  logic [7:0] s0_byte;
  logic [7:0] s0_code;
  logic       s0_first;
  logic       s0_last;
  logic       s0_empty;

  // name state
  logic [7:0]    held_high_byte, held_high_byte_next;
  logic          have_high_byte, have_high_byte_next;
  logic          wide_mode, wide_mode_next;
  logic          code_error, code_error_next;
  logic [CW-1:0] output_count, output_count_next;

  logic s0_adv;
  logic in_take;

  function automatic logic [8:0] sat_len(input logic [SW-1:0] v);
    sat_len = (v > SW'(LEN_MAX)) ? LEN_MAX : v[8:0];
  endfunction

  always_comb begin
    logic          mode;
    logic          err;
    logic [CW-1:0] cnt;
    logic          have;
    logic [7:0]    held;
    logic          hc;
    logic [15:0]   c;
    logic [1:0]    n_enc;
    logic          emit;
    run_t          r;

    mode = s0_first ? (s0_code == CODE_WIDE) : wide_mode;
    err  = s0_first ? (s0_code != CODE_NARROW && s0_code != CODE_WIDE) : code_error;
    cnt  = s0_first ? '0 : output_count;
    have = s0_first ? 1'b0 : have_high_byte;
    held = s0_first ? 8'd0 : held_high_byte;
    hc   = 1'b0;
    c    = 16'd0;
    r    = '0;

    held_high_byte_next = held;
    have_high_byte_next = have;

    if (!err) begin
      if (!mode) begin
        c  = {8'd0, s0_byte};
        hc = 1'b1;
      end else if (have) begin
        c  = {held, s0_byte};
        hc = 1'b1;
        have_high_byte_next = 1'b0;
      end else if (s0_last) begin
        c  = {s0_byte, 8'd0};
        hc = 1'b1;
      end else begin
        held_high_byte_next = s0_byte;
        have_high_byte_next = 1'b1;
      end
    end

    if (c < ONE_BYTE_MAX) begin
      n_enc = 2'd1;
    end else if (c < TWO_BYTE_MAX) begin
      n_enc = 2'd2;
    end else begin
      n_enc = 2'd3;
    end

    emit = hc && (cnt <= CW'(NAME_LIMIT - 3));

    r.name_last = s0_last;
    r.bad       = err;
    output_count_next = cnt;

    if (emit) begin
      r.count = n_enc;
      output_count_next = CW'(cnt + CW'(n_enc));
      case (n_enc)
        2'd1: begin
          r.slot[0].data = c[7:0];
        end
        2'd2: begin
          r.slot[0].data = LEAD2 | {3'd0, c[10:6]};
          r.slot[1].data = CONT | {2'd0, c[5:0]};
        end
        default: begin
          r.slot[0].data = LEAD3 | {4'd0, c[15:12]};
          r.slot[1].data = CONT | {2'd0, c[11:6]};
          r.slot[2].data = CONT | {2'd0, c[5:0]};
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        r.slot[k].data_valid = 1'b1;
        r.slot[k].len = sat_len(SW'(cnt) + SW'(k + 1));
      end
    end else if (s0_last) begin
      // bare word closes the name
      r.count = 2'd1;
      r.slot[0].len = err ? 9'd0 : sat_len(SW'(cnt));
    end else begin
      r.count = 2'd0;
    end

    wide_mode_next  = mode;
    code_error_next = err;
    if (s0_last) begin
      output_count_next   = '0;
      have_high_byte_next = 1'b0;
      held_high_byte_next = 8'd0;
    end

    if (s0_empty) begin
      r = '0;
      r.count     = 2'd1;
      r.name_last = 1'b1;
      wide_mode_next      = 1'b0;
      code_error_next     = 1'b0;
      output_count_next   = '0;
      have_high_byte_next = 1'b0;
      held_high_byte_next = 8'd0;
    end

    rec = r;
  end

  assign rec_valid = s0_valid && (rec.count != 2'd0);
  assign s0_adv    = s0_valid && ((rec.count == 2'd0) || !rec_stall);
  assign in_stall  = s0_valid && !s0_adv;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid       <= 1'b0;
      held_high_byte <= 8'd0;
      have_high_byte <= 1'b0;
      wide_mode      <= 1'b0;
      code_error     <= 1'b0;
      output_count   <= '0;
    end else begin
      if (in_take) begin
        s0_valid <= 1'b1;
      end else if (s0_adv) begin
        s0_valid <= 1'b0;
      end
      if (s0_adv) begin
        held_high_byte <= held_high_byte_next;
        have_high_byte <= have_high_byte_next;
        wide_mode      <= wide_mode_next;
        code_error     <= code_error_next;
        output_count   <= output_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_byte  <= in_byte;
      s0_code  <= compression_code;
      s0_first <= first_of_name;
      s0_last  <= last_of_name;
      s0_empty <= empty_name;
    end
  end

endmodule

@@ rtl/core/cs0u_serial.sv @@
// run register and output register, one utf-8 word per cycle while the output is not stalled
// depends on cs0u_pkg
module cs0u_serial (
  input  logic           clk,
  input  logic           rst,
  input  logic           rec_valid,
  output logic           rec_stall,
  input  cs0u_pkg::run_t rec,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           byte_valid,
  output logic           last_of_run,
  output logic           name_done,
  output logic [8:0]     name_length,
  output logic           bad_code
);
  import cs0u_pkg::*;

  logic       run_valid;
  run_t       run;
  logic [1:0] idx;
  logic       move;
  logic       run_end;
  slot_t      cur;

  assign cur       = run.slot[idx];
  assign move      = run_valid && (!out_valid || !out_stall);
  assign run_end   = move && (idx == run.count - 2'd1);
  assign rec_stall = run_valid && !run_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (rec_valid && !rec_stall) begin
        run_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (run_end) begin
        run_valid <= 1'b0;
      end else if (move) begin
        idx <= idx + 2'd1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && !rec_stall) begin
      run <= rec;
    end
    if (move) begin
      out_byte    <= cur.data;
      byte_valid  <= cur.data_valid;
      last_of_run <= run_end;
      name_done   <= run_end && run.name_last;
      name_length <= cur.len;
      bad_code    <= run.bad;
    end
  end

endmodule

@@ rtl/core/cs0_to_utf8_encoder.sv @@
// cs0 to utf-8 encoder: an accepted input word passes the input and run registers
// before its first result word is on the output register; a new input word can be
// taken every cycle while the one ahead gives at most one word and the output is
// not stalled; each input word gives zero to three result words, one per cycle
// unless stalled (a held high byte or a non-last unknown-code word gives none)
// reset: synchronous, clears the input, run and output valids, mode, error flag, pairing and count
`include "assert_macros.svh"

module cs0_to_utf8_encoder #(
  parameter int NAME_LIMIT = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic [7:0] compression_code,
  input  logic       first_of_name,
  input  logic       last_of_name,
  input  logic       empty_name,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       last_of_run,
  output logic       name_done,
  output logic [8:0] name_length,
  output logic       bad_code
);
  import cs0u_pkg::*;

  // run record handed from the name-state stage to the serializer
  logic rec_valid;
  logic rec_stall;
  run_t rec;

  // input register, pairing of wide characters, utf-8 expansion, limit check
  cs0u_front #(
    .NAME_LIMIT (NAME_LIMIT)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .compression_code (compression_code),
    .first_of_name    (first_of_name),
    .last_of_name     (last_of_name),
    .empty_name       (empty_name),
    .rec_valid        (rec_valid),
    .rec_stall        (rec_stall),
    .rec              (rec)
  );

  // holds one run and plays it out a word at a time
  cs0u_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec_stall   (rec_stall),
    .rec         (rec),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .last_of_run (last_of_run),
    .name_done   (name_done),
    .name_length (name_length),
    .bad_code    (bad_code)
  );

  // a bare word only ever closes a name
  `ASSERT_IMPLIES(a_bare_closes, clk, rst, out_valid && !byte_valid,
                  last_of_run && name_done, "bare word not closing name")
  // the end of a name is always the end of a run
  `ASSERT_IMPLIES(a_done_ends_run, clk, rst, out_valid && name_done, last_of_run,
                  "name done mid run")
  // an unknown code never lets data through
  `ASSERT_NEVER(a_bad_no_data, clk, rst, out_valid && byte_valid && bad_code,
                "data word with bad code")
  // every data word counts itself
  `ASSERT_IMPLIES(a_len_counts, clk, rst, out_valid && byte_valid, name_length != 9'd0,
                  "data word with zero length")

endmodule
